/* rtl/core/cfpt_pkg.sv */
// Package for the complex field phase tilt unit.
// Holds configuration register codes, quadrant codes, sizing defaults, field
// widths and the quarter-wave sine table generator; no dependencies.
`default_nettype none

package cfpt_pkg;

	// Default sizing
	localparam int unsigned GRID_SIZE_DEF       = 1024;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	// Field widths
	localparam int unsigned SAMPLE_W = 18;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned CENTRE_W = 11;
	localparam int unsigned STEP_W   = 32;
	localparam int unsigned COEF_W   = 17;   // unsigned Q1.16 table entry
	localparam int unsigned CFG_AW   = 2;

	// Pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Configuration register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_ROW_STEP = 2'd0,
		REG_COL_STEP = 2'd1,
		REG_CENTRE   = 2'd2
	} cfg_reg_t;

	// Phase quadrants, from the two top phase bits
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Table entry k: sin(pi/2 * k / 2^bits) in Q1.16, from a truncated Q30
	// Taylor series rounded half up. Evaluated at elaboration only.
	function automatic logic [COEF_W-1:0] sine_entry(input int unsigned k,
		input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		x    = (HALF_PI_Q30 * 64'(k)) >> bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		q = (sum + 64'd8192) >> 14;
		if (q > 64'd65536) begin
			q = 64'd65536;
		end
		return q[COEF_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/complex_field_phase_tilt_unit.sv */
// Complex field phase tilt unit: linear 2-D phase ramp applied to a stream of
// complex grid samples, with quarter-wave sine lookup, rounding and saturation.
// Depends on cfpt_pkg.
//
// Items pass through nine registered stages from input request to result request,
// one item per cycle while the output accepts; every stage carries a valid bit and stalls only when full.
// The nine stages hold two phase multipliers, the sine table read and four
// rotation multipliers; each stage takes a new item a cycle unless stalled.
// Reset clears all valid bits and the configuration registers (steps to zero,
// centre to GRID_SIZE/2); the sine table is a constant and needs no fill.
`default_nettype none

module complex_field_phase_tilt_unit
	import cfpt_pkg::*;
#(
	parameter int unsigned GRID_SIZE       = GRID_SIZE_DEF,
	parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [STEP_W-1:0] cfg_wdata,
	// input stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: sample_re[17:0], sample_im[35:18], row_index[45:36], col_index[55:46]
	input  wire logic [55:0]       s_axis_tdata,
	// output stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// tdata: out_re[17:0], out_im[35:18], zero pad[39:36]
	output logic [39:0]            m_axis_tdata,
	// tuser: saturated[0]
	output logic                   m_axis_tuser
);

	localparam int unsigned TabN  = 1 << SINE_TABLE_BITS;
	localparam int unsigned TabAw = SINE_TABLE_BITS + 1;
	localparam logic [CENTRE_W-1:0] CentreReset = CENTRE_W'(GRID_SIZE / 2);
	localparam logic [30:0] RoundHalf = 31'(1 << (29 - SINE_TABLE_BITS));
	localparam logic signed [21:0] OutMax = 22'sd131071;
	localparam logic signed [21:0] OutMin = -22'sd131072;

	// Quarter-wave sine table, fixed at elaboration
	logic [COEF_W-1:0] sine_rom [TabN+1];

	for (genvar k = 0; k <= TabN; k++) begin : g_tab
		assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
	end

	// Configuration registers
	logic signed [STEP_W-1:0]  row_step_q;
	logic signed [STEP_W-1:0]  col_step_q;
	logic [CENTRE_W-1:0]       centre_q;

	// write the addressed register, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_step_q <= '0;
			col_step_q <= '0;
			centre_q   <= CentreReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ROW_STEP: row_step_q <= cfg_wdata;
				REG_COL_STEP: col_step_q <= cfg_wdata;
				REG_CENTRE:   centre_q   <= cfg_wdata[CENTRE_W-1:0];
				default:      ;
			endcase
		end
	end

	// Stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	// a stage takes new data when empty or when its content moves on
	assign rdy_s9 = !v_s9 || m_axis_tready;
	assign rdy_s8 = !v_s8 || rdy_s9;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
			if (rdy_s9) v_s9 <= v_s8;
		end
	end

	// Input unpacking
	logic signed [SAMPLE_W-1:0] in_re, in_im;
	logic [INDEX_W-1:0]         in_row, in_col;

	assign in_re  = s_axis_tdata[17:0];
	assign in_im  = s_axis_tdata[35:18];
	assign in_row = s_axis_tdata[45:36];
	assign in_col = s_axis_tdata[55:46];

	// Stage 1: index offsets from the centre
	logic signed [SAMPLE_W-1:0] re_s1, im_s1;
	logic signed [11:0]         dr_s1, dc_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			re_s1 <= in_re;
			im_s1 <= in_im;
			dr_s1 <= $signed({2'b00, in_row}) - $signed({1'b0, centre_q});
			dc_s1 <= $signed({2'b00, in_col}) - $signed({1'b0, centre_q});
		end
	end

	// Stage 2: phase terms, kept modulo one turn
	logic signed [SAMPLE_W-1:0] re_s2, im_s2;
	logic [STEP_W-1:0]          pr_s2, pc_s2;
	logic signed [43:0]         pr_full, pc_full;

	assign pr_full = dr_s1 * row_step_q;
	assign pc_full = dc_s1 * col_step_q;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			re_s2 <= re_s1;
			im_s2 <= im_s1;
			pr_s2 <= pr_full[STEP_W-1:0];
			pc_s2 <= pc_full[STEP_W-1:0];
		end
	end

	// Stage 3: total phase
	logic signed [SAMPLE_W-1:0] re_s3, im_s3;
	logic [STEP_W-1:0]          phase_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			re_s3    <= re_s2;
			im_s3    <= im_s2;
			phase_s3 <= pr_s2 + pc_s2;
		end
	end

	// Stage 4: quadrant and rounded table addresses
	logic signed [SAMPLE_W-1:0] re_s4, im_s4;
	logic [1:0]                 quad_s4;
	logic [TabAw-1:0]           r_s4, nr_s4;
	logic [30:0]                frac_rnd;
	logic [TabAw-1:0]           r_next;

	assign frac_rnd = {1'b0, phase_s3[29:0]} + RoundHalf;
	assign r_next   = frac_rnd[30:30-SINE_TABLE_BITS];

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			re_s4   <= re_s3;
			im_s4   <= im_s3;
			quad_s4 <= phase_s3[31:30];
			r_s4    <= r_next;
			nr_s4   <= TabAw'(TabN) - r_next;
		end
	end

	// Stage 5: table reads
	logic signed [SAMPLE_W-1:0] re_s5, im_s5;
	logic [1:0]                 quad_s5;
	logic [COEF_W-1:0]          tr_s5, tnr_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			re_s5   <= re_s4;
			im_s5   <= im_s4;
			quad_s5 <= quad_s4;
			tr_s5   <= sine_rom[r_s4];
			tnr_s5  <= sine_rom[nr_s4];
		end
	end

	// Stage 6: fold the quadrant into signed sine and cosine
	logic signed [SAMPLE_W-1:0] re_s6, im_s6;
	logic signed [17:0]         sin_s6, cos_s6;
	logic signed [17:0]         pos_r, pos_nr, sin_sel, cos_sel;

	assign pos_r  = $signed({1'b0, tr_s5});
	assign pos_nr = $signed({1'b0, tnr_s5});

	always_comb begin
		case (quad_t'(quad_s5))
			QUAD_0:  begin sin_sel = pos_r;   cos_sel = pos_nr;  end
			QUAD_1:  begin sin_sel = pos_nr;  cos_sel = -pos_r;  end
			QUAD_2:  begin sin_sel = -pos_r;  cos_sel = -pos_nr; end
			QUAD_3:  begin sin_sel = -pos_nr; cos_sel = pos_r;   end
			default: begin sin_sel = pos_r;   cos_sel = pos_nr;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			re_s6  <= re_s5;
			im_s6  <= im_s5;
			sin_s6 <= sin_sel;
			cos_s6 <= cos_sel;
		end
	end

	// Stage 7: rotation products
	logic signed [35:0] p_rc_s7, p_is_s7, p_rs_s7, p_ic_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			p_rc_s7 <= re_s6 * cos_s6;
			p_is_s7 <= im_s6 * sin_s6;
			p_rs_s7 <= re_s6 * sin_s6;
			p_ic_s7 <= im_s6 * cos_s6;
		end
	end

	// Stage 8: rotated sums
	logic signed [36:0] yr_s8, yi_s8;

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			yr_s8 <= $signed({p_rc_s7[35], p_rc_s7}) - $signed({p_is_s7[35], p_is_s7});
			yi_s8 <= $signed({p_rs_s7[35], p_rs_s7}) + $signed({p_ic_s7[35], p_ic_s7});
		end
	end

	// Stage 9: round half up, saturate, hold for the output request
	logic signed [37:0]         yr_rnd, yi_rnd;
	logic signed [21:0]         yr_sh, yi_sh;
	logic signed [SAMPLE_W-1:0] yr_sat, yi_sat;
	logic                       yr_clip, yi_clip;
	logic signed [SAMPLE_W-1:0] out_re_s9, out_im_s9;
	logic                       sat_s9;

	assign yr_rnd = $signed({yr_s8[36], yr_s8}) + 38'sd32768;
	assign yi_rnd = $signed({yi_s8[36], yi_s8}) + 38'sd32768;
	assign yr_sh  = yr_rnd[37:16];
	assign yi_sh  = yi_rnd[37:16];

	always_comb begin
		yr_clip = 1'b1;
		yi_clip = 1'b1;
		if (yr_sh > OutMax) begin
			yr_sat = OutMax[SAMPLE_W-1:0];
		end else if (yr_sh < OutMin) begin
			yr_sat = OutMin[SAMPLE_W-1:0];
		end else begin
			yr_sat  = yr_sh[SAMPLE_W-1:0];
			yr_clip = 1'b0;
		end
		if (yi_sh > OutMax) begin
			yi_sat = OutMax[SAMPLE_W-1:0];
		end else if (yi_sh < OutMin) begin
			yi_sat = OutMin[SAMPLE_W-1:0];
		end else begin
			yi_sat  = yi_sh[SAMPLE_W-1:0];
			yi_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			out_re_s9 <= yr_sat;
			out_im_s9 <= yi_sat;
			sat_s9    <= yr_clip || yi_clip;
		end
	end

	// Output packing
	assign m_axis_tvalid = v_s9;
	assign m_axis_tdata  = {4'b0000, out_im_s9, out_re_s9};
	assign m_axis_tuser  = sat_s9;

endmodule

`default_nettype wire
